[rtl/rpn_pkg.sv]
package rpn_pkg;

  localparam int VAL_W = 32;
  localparam int PROD_W = 2 * VAL_W;

  typedef enum logic [2:0] {
    CMD_NUM = 3'd0,
    CMD_ADD = 3'd1,
    CMD_SUB = 3'd2,
    CMD_MUL = 3'd3,
    CMD_DIV = 3'd4,
    CMD_END = 3'd5
  } rpn_cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic       push;
    logic       set_err;
    logic [1:0] err_code;
    logic       rd_start;
    logic       alu_commit;
    logic       sub;
    logic       mul_load;
    logic       mul_commit;
    logic       div_start;
    logic       div_commit;
    logic       finish;
  } rpn_ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic depth_lt2;
    logic full;
    logic err_active;
    logic tos_zero;
    logic div_done;
  } rpn_stat_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = {{VAL_W{1'b0}}, VAL_MAX};
    lo = {{VAL_W{1'b1}}, VAL_MIN};
    if (v > hi) begin
      return VAL_MAX;
    end else if (v < lo) begin
      return VAL_MIN;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

[rtl/rpn_stack_calculator.sv]
// Reverse Polish evaluator over signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default) with an operand stack of STACK_DEPTH entries. Each item is
// a token: push, add, subtract, multiply, divide or end; only the end token
// gives a result (value and status), after which the stack and error are
// cleared. All arithmetic saturates to 32 bits. The top of stack sits in a
// register and the rest in a one-write, one-read RAM, so push, end, ignored
// tokens and operators that latch an error need no RAM read, add and subtract
// take a RAM read and the write back, multiply a RAM read, a registered
// product, then shift and saturate, and divide a RAM read, a divider load,
// the restoring divider at one quotient bit a cycle, and the write back. A
// new item is taken only when the previous one is done; a result waiting on
// out_ready holds off the next item only until it is taken.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_cmd,
  input  logic signed [VAL_W-1:0] in_operand_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_final_value,
  output logic [1:0]              out_status
);

  rpn_ctl_t  ctl;
  rpn_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operand_value (in_operand_value),
    .ctl              (ctl),
    .stat             (stat),
    .out_final_value  (out_final_value),
    .out_status       (out_status)
  );

endmodule

[rtl/rpn_ram.sv]
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rpn_div.sv]
module rpn_div import rpn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] dividend,
  input  logic signed [VAL_W-1:0] divisor,
  output logic                    done,
  output logic signed [VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0]  num_mag;
  logic [VAL_W-1:0]  den_mag;
  logic [PROD_W-1:0] num_wide;

  logic [VAL_W-1:0] rem_r,  rem_nxt;
  logic [VAL_W-1:0] quo_r,  quo_nxt;
  logic [VAL_W-1:0] den_r,  den_nxt;
  logic             neg_r,  neg_nxt;
  logic             ovf_r,  ovf_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   trial_diff;

  assign num_mag  = dividend[VAL_W-1] ? (~dividend + 1'b1) : dividend;
  assign den_mag  = divisor[VAL_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign num_wide = {{VAL_W{1'b0}}, num_mag} << FRAC_BITS;

  // one quotient bit a cycle; the partial remainder stays below the divisor unless the quotient overflows
  assign trial      = {rem_r, quo_r[VAL_W-1]};
  assign trial_diff = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      den_nxt  = den_mag;
      neg_nxt  = dividend[VAL_W-1] ^ divisor[VAL_W-1];
      // high half not below the divisor: quotient needs more than 32 bits
      ovf_nxt  = num_wide[PROD_W-1:VAL_W] >= den_mag;
      rem_nxt  = num_wide[PROD_W-1:VAL_W];
      quo_nxt  = num_wide[VAL_W-1:0];
      cnt_nxt  = CNT_W'(VAL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial_diff[VAL_W]) begin
        rem_nxt = trial_diff[VAL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VAL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  always_comb begin
    if (ovf_r) begin
      quotient = neg_r ? VAL_MIN : VAL_MAX;
    end else if (neg_r) begin
      quotient = (quo_r > VAL_MIN) ? VAL_MIN : (~quo_r + 1'b1);
    end else begin
      quotient = quo_r[VAL_W-1] ? VAL_MAX : quo_r;
    end
  end

  assign done = done_r;

endmodule

[rtl/rpn_dp.sv]
module rpn_dp import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [VAL_W-1:0] in_operand_value,
  input  rpn_ctl_t                ctl,
  output rpn_stat_t               stat,
  output logic signed [VAL_W-1:0] out_final_value,
  output logic [1:0]              out_status
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);

  logic signed [VAL_W-1:0]  tos_r,   tos_nxt;
  logic [DEPTH_W-1:0]       depth_r, depth_nxt;
  logic [1:0]               err_r,   err_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  val_r,   val_nxt;
  logic [1:0]               status_r, status_nxt;

  logic [DEPTH_W-1:0]       depth_m1;
  logic [DEPTH_W-1:0]       depth_m2;
  logic                     ram_we;
  logic signed [VAL_W-1:0]  lower;
  logic signed [VAL_W:0]    sum;
  logic signed [PROD_W-1:0] sum_wide;
  logic signed [PROD_W-1:0] prod_sh;
  logic                     div_done;
  logic signed [VAL_W-1:0]  div_q;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);

  // the top of stack lives in tos_r; the memory holds the entries below it
  assign ram_we = ctl.push && (depth_r != '0);

  rpn_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_m1[ADDR_W-1:0]),
    .wdata (tos_r),
    .re    (ctl.rd_start),
    .raddr (depth_m2[ADDR_W-1:0]),
    .rdata (lower)
  );

  rpn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (lower),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sum = ctl.sub ? ({lower[VAL_W-1], lower} - {tos_r[VAL_W-1], tos_r})
                       : ({lower[VAL_W-1], lower} + {tos_r[VAL_W-1], tos_r});
  assign sum_wide = {{(PROD_W-VAL_W-1){sum[VAL_W]}}, sum};
  // arithmetic shift rounds toward minus infinity
  assign prod_sh  = prod_r >>> FRAC_BITS;

  always_comb begin
    tos_nxt    = tos_r;
    depth_nxt  = depth_r;
    err_nxt    = err_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    if (ctl.finish) begin
      if (err_r != ST_OK) begin
        val_nxt    = '0;
        status_nxt = err_r;
      end else if (depth_r == DEPTH_W'(1)) begin
        val_nxt    = tos_r;
        status_nxt = ST_OK;
      end else begin
        val_nxt    = '0;
        status_nxt = ST_MALFORMED;
      end
      depth_nxt = '0;
      err_nxt   = ST_OK;
    end
    if (ctl.push) begin
      tos_nxt   = in_operand_value;
      depth_nxt = depth_r + DEPTH_W'(1);
    end
    if (ctl.set_err) begin
      err_nxt = ctl.err_code;
    end
    if (ctl.alu_commit) begin
      tos_nxt   = sat_val(sum_wide);
      depth_nxt = depth_m1;
    end
    if (ctl.mul_commit) begin
      tos_nxt   = sat_val(prod_sh);
      depth_nxt = depth_m1;
    end
    if (ctl.div_commit) begin
      tos_nxt   = div_q;
      depth_nxt = depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ST_OK;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
    tos_r    <= tos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    if (ctl.mul_load) begin
      prod_r <= lower * tos_r;
    end
  end

  assign stat.depth_lt2  = depth_r < DEPTH_W'(2);
  assign stat.full       = depth_r == DEPTH_W'(STACK_DEPTH);
  assign stat.err_active = err_r != ST_OK;
  assign stat.tos_zero   = tos_r == '0;
  assign stat.div_done   = div_done;

  assign out_final_value = val_r;
  assign out_status      = status_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> (depth_r == '0) && (err_r == ST_OK))
    else $error("end token did not clear stack and error");
  a_op_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.rd_start || ctl.alu_commit || ctl.mul_load || ctl.div_start)
      |-> (depth_r >= DEPTH_W'(2)) && (err_r == ST_OK))
    else $error("operator issued without two operands");
`endif

endmodule

[rtl/rpn_ctrl.sv]
module rpn_ctrl import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  input  rpn_stat_t  stat,
  output rpn_ctl_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV
  } state_t;

  state_t   state_r,     state_nxt;
  rpn_cmd_t op_r,        op_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     accept;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ctl       = '0;
    in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    accept    = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (rpn_cmd_t'(in_cmd))
            CMD_END: begin
              ctl.finish = 1'b1;
            end
            CMD_NUM: begin
              if (!stat.err_active) begin
                if (stat.full) begin
                  ctl.set_err  = 1'b1;
                  ctl.err_code = ST_OVERFLOW;
                end else begin
                  ctl.push = 1'b1;
                end
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (!stat.err_active) begin
                if (stat.depth_lt2) begin
                  ctl.set_err  = 1'b1;
                  ctl.err_code = ST_MALFORMED;
                end else if ((rpn_cmd_t'(in_cmd) == CMD_DIV) && stat.tos_zero) begin
                  ctl.set_err  = 1'b1;
                  ctl.err_code = ST_DIVZERO;
                end else begin
                  // fetch the entry under the top of stack
                  ctl.rd_start = 1'b1;
                  op_nxt       = rpn_cmd_t'(in_cmd);
                  state_nxt    = S_READ;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
        case (op_r)
          CMD_ADD: ctl.alu_commit = 1'b1;
          CMD_SUB: begin
            ctl.alu_commit = 1'b1;
            ctl.sub        = 1'b1;
          end
          CMD_MUL: begin
            ctl.mul_load = 1'b1;
            state_nxt    = S_MUL;
          end
          CMD_DIV: begin
            ctl.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        ctl.mul_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          ctl.div_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= CMD_NUM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide wait");
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> out_valid_r)
    else $error("end token gave no result");
`endif

endmodule
